[hdl/tlb_fifo_lru_defines.svh]
// ---------------------------------------------------------------------------
// tlb_fifo_lru assertion macros
// Concurrent assertion wrappers sampled on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TLB_FIFO_LRU_DEFINES_SVH
`define TLB_FIFO_LRU_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define TLBFL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlb_fifo_lru: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define TLBFL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlb_fifo_lru: next-cycle check failed");

`endif

[hdl/tlbfl_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlbfl_pkg
// Shared constants, codes, controller states and the control/status bundles
// between the TLB controller and datapath.
// ---------------------------------------------------------------------------
package tlbfl_pkg;

    // Default sizes
    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_PAGE_BITS   = 20;
    localparam int DEF_FRAME_BITS  = 20;

    // Fixed field widths
    localparam int CMD_BITS       = 2;
    localparam int LIMIT_BITS     = 5;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 5;

    // Operation codes
    localparam logic [CMD_BITS-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_FLUSH  = 2'd2;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_ENTRIES_IN_USE = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REPLACE_MODE   = 1'd1;

    // Replacement policy
    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_LRU  = 1'b1;

    // Register reset values
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVICT,
        ST_WRITE,
        ST_RESULT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;      // latch input transaction, clear working result
        logic flush;       // invalidate every entry
        logic scan_issue;  // read entry with the current insertion rank
        logic scan_cmp;    // compare the entry read last cycle
        logic evict;       // drop the replacement victim
        logic write;       // fill the lowest free slot
        logic load_out;    // move working result into output register
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic lim_zero;    // TLB disabled
        logic occ_zero;    // no valid entries
        logic need_evict;  // occupancy at or above limit
        logic scan_more;   // insertion ranks left to read
        logic out_free;    // output register can take a result
    } dp_status_t;

endpackage

[hdl/tlbfl_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlbfl_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tlbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/tlbfl_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlbfl_ctrl
// Sequencer for the TLB: accepts one transaction at a time, walks the
// lookup scan, eviction and fill steps, and hands the result to the
// output register.
// ---------------------------------------------------------------------------
module tlbfl_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [tlbfl_pkg::CMD_BITS-1:0]     command,
    output logic                               cfg_ready,
    input  tlbfl_pkg::dp_status_t              status,
    output tlbfl_pkg::ctrl_cmd_t               cmd
);

    tlbfl_pkg::state_t state_reg, state_next;
    logic              pend_reg, pend_next;
    logic              live_reg;

    // State, scan pipeline flag and out-of-reset flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlbfl_pkg::ST_IDLE;
            pend_reg  <= 1'b0;
            live_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            live_reg  <= 1'b1;
        end
    end

    assign in_stall  = !live_reg || (state_reg != tlbfl_pkg::ST_IDLE);
    assign cfg_ready = live_reg;

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        pend_next  = pend_reg;
        case (state_reg)
            tlbfl_pkg::ST_IDLE:
            begin
                if (in_valid && live_reg)
                begin
                    cmd.accept = 1'b1;
                    case (command)
                        tlbfl_pkg::CMD_LOOKUP:
                        begin
                            if (!status.lim_zero && !status.occ_zero)
                            begin
                                state_next = tlbfl_pkg::ST_SCAN;
                                pend_next  = 1'b0;
                            end
                            else
                            begin
                                state_next = tlbfl_pkg::ST_RESULT;
                            end
                        end
                        tlbfl_pkg::CMD_INSERT:
                        begin
                            if (status.lim_zero)
                            begin
                                state_next = tlbfl_pkg::ST_RESULT;
                            end
                            else if (status.need_evict)
                            begin
                                state_next = tlbfl_pkg::ST_EVICT;
                            end
                            else
                            begin
                                state_next = tlbfl_pkg::ST_WRITE;
                            end
                        end
                        tlbfl_pkg::CMD_FLUSH:
                        begin
                            cmd.flush  = 1'b1;
                            state_next = tlbfl_pkg::ST_RESULT;
                        end
                        default:
                        begin
                            state_next = tlbfl_pkg::ST_RESULT;
                        end
                    endcase
                end
            end
            // Read one rank per cycle, compare the entry read the cycle before
            tlbfl_pkg::ST_SCAN:
            begin
                cmd.scan_issue = status.scan_more;
                cmd.scan_cmp   = pend_reg;
                pend_next      = status.scan_more;
                if (!status.scan_more)
                begin
                    state_next = tlbfl_pkg::ST_RESULT;
                end
            end
            tlbfl_pkg::ST_EVICT:
            begin
                cmd.evict  = 1'b1;
                state_next = tlbfl_pkg::ST_WRITE;
            end
            tlbfl_pkg::ST_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = tlbfl_pkg::ST_RESULT;
            end
            tlbfl_pkg::ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = tlbfl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlbfl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/tlbfl_dp.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlbfl_dp
// TLB datapath: configuration registers, per-entry valid bits and ranks,
// page/frame RAM, scan compare, victim and free-slot selection, and the
// output register.
// ---------------------------------------------------------------------------
module tlbfl_dp #(
    parameter int MAX_ENTRIES = tlbfl_pkg::DEF_MAX_ENTRIES,
    parameter int PAGE_BITS   = tlbfl_pkg::DEF_PAGE_BITS,
    parameter int FRAME_BITS  = tlbfl_pkg::DEF_FRAME_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tlbfl_pkg::ctrl_cmd_t                 cmd,
    output tlbfl_pkg::dp_status_t                status,
    input  logic [PAGE_BITS-1:0]                 page_number,
    input  logic [FRAME_BITS-1:0]                frame_number,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [tlbfl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tlbfl_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 hit,
    output logic [FRAME_BITS-1:0]                found_frame
);

    localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int LIM_W  = (CNT_W > tlbfl_pkg::LIMIT_BITS) ? CNT_W : tlbfl_pkg::LIMIT_BITS;
    localparam int DATA_W = PAGE_BITS + FRAME_BITS;

    // Configuration
    logic [tlbfl_pkg::LIMIT_BITS-1:0] limit_reg;
    logic                             mode_reg;

    // Entry state
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    logic [RANK_W-1:0]      rec_reg   [MAX_ENTRIES];
    logic [RANK_W-1:0]      rec_next  [MAX_ENTRIES];
    logic [RANK_W-1:0]      ins_reg   [MAX_ENTRIES];
    logic [RANK_W-1:0]      ins_next  [MAX_ENTRIES];
    logic [CNT_W-1:0]       occ_reg, occ_next;

    // Transaction and scan registers
    logic [PAGE_BITS-1:0]   page_reg;
    logic [FRAME_BITS-1:0]  frame_reg;
    logic [CNT_W-1:0]       scan_k_reg;
    logic [MAX_ENTRIES-1:0] scan_oh_reg;
    logic                   scan_ok_reg;
    logic                   hit_reg;
    logic [FRAME_BITS-1:0]  found_reg;

    // Output register
    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic [FRAME_BITS-1:0]  out_frame_reg;

    // Combinational selections
    logic [MAX_ENTRIES-1:0] scan_oh, victim_oh, free_oh;
    logic [RANK_W-1:0]      scan_idx, free_idx;
    logic                   scan_any, victim_any, free_any;
    logic [RANK_W-1:0]      sel_rec, vic_rec, vic_ins;
    logic [LIM_W-1:0]       lim_wide, occ_wide;
    logic [DATA_W-1:0]      ram_rd_data;
    logic [PAGE_BITS-1:0]   rd_page;
    logic [FRAME_BITS-1:0]  rd_frame;
    logic                   cmp_match;
    logic [RANK_W-1:0]      occ_rank, occ_top_rank;

    // Effective limit and status
    assign lim_wide = (LIM_W'(limit_reg) > LIM_W'(MAX_ENTRIES)) ? LIM_W'(MAX_ENTRIES)
                                                               : LIM_W'(limit_reg);
    assign occ_wide = LIM_W'(occ_reg);

    assign status.lim_zero   = (limit_reg == '0);
    assign status.occ_zero   = (occ_reg == '0);
    assign status.need_evict = (occ_wide >= lim_wide);
    assign status.scan_more  = (scan_k_reg < occ_reg);
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign occ_rank     = occ_reg[RANK_W-1:0];
    assign occ_top_rank = (occ_reg - CNT_W'(1)) >> 0 == '0 ? '0 : occ_rank - RANK_W'(1);

    // Entry lookup, victim and free-slot selection
    always_comb
    begin
        scan_idx = '0;
        free_idx = '0;
        free_oh  = '0;
        sel_rec  = '0;
        vic_rec  = '0;
        vic_ins  = '0;
        for (int j = 0; j < MAX_ENTRIES; j++)
        begin
            scan_oh[j] = valid_reg[j] && (ins_reg[j] == scan_k_reg[RANK_W-1:0]);
            victim_oh[j] = valid_reg[j] &&
                           ((mode_reg == tlbfl_pkg::MODE_LRU) ? (rec_reg[j] == '0)
                                                             : (ins_reg[j] == '0));
            if (scan_oh[j])
            begin
                scan_idx = scan_idx | RANK_W'(j);
            end
            if (scan_oh_reg[j])
            begin
                sel_rec = sel_rec | rec_reg[j];
            end
            if (victim_oh[j])
            begin
                vic_rec = vic_rec | rec_reg[j];
                vic_ins = vic_ins | ins_reg[j];
            end
        end
        // Lowest free slot wins
        for (int j = MAX_ENTRIES - 1; j >= 0; j--)
        begin
            if (!valid_reg[j])
            begin
                free_idx = RANK_W'(j);
                free_oh  = '0;
                free_oh[j] = 1'b1;
            end
        end
        scan_any   = |scan_oh;
        victim_any = |victim_oh;
        free_any   = !(&valid_reg);
    end

    // Page and frame storage
    tlbfl_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.write && free_any),
        .wr_addr (free_idx),
        .wr_data ({page_reg, frame_reg}),
        .rd_en   (cmd.scan_issue),
        .rd_addr (scan_idx),
        .rd_data (ram_rd_data)
    );

    assign rd_page   = ram_rd_data[DATA_W-1 -: PAGE_BITS];
    assign rd_frame  = ram_rd_data[FRAME_BITS-1:0];
    assign cmp_match = cmd.scan_cmp && scan_ok_reg && (rd_page == page_reg);

    // Next entry state
    always_comb
    begin
        valid_next = valid_reg;
        rec_next   = rec_reg;
        ins_next   = ins_reg;
        occ_next   = occ_reg;
        if (cmd.flush)
        begin
            valid_next = '0;
            occ_next   = '0;
        end
        else if (cmp_match)
        begin
            // Matched entry becomes most recent, those above it move down
            for (int j = 0; j < MAX_ENTRIES; j++)
            begin
                if (scan_oh_reg[j])
                begin
                    rec_next[j] = occ_top_rank;
                end
                else if (valid_reg[j] && (rec_reg[j] > sel_rec))
                begin
                    rec_next[j] = rec_reg[j] - RANK_W'(1);
                end
            end
        end
        else if (cmd.evict && victim_any)
        begin
            // Close the gap the victim leaves in both orders
            for (int j = 0; j < MAX_ENTRIES; j++)
            begin
                if (victim_oh[j])
                begin
                    valid_next[j] = 1'b0;
                end
                else if (valid_reg[j])
                begin
                    if (rec_reg[j] > vic_rec)
                    begin
                        rec_next[j] = rec_reg[j] - RANK_W'(1);
                    end
                    if (ins_reg[j] > vic_ins)
                    begin
                        ins_next[j] = ins_reg[j] - RANK_W'(1);
                    end
                end
            end
            occ_next = occ_reg - CNT_W'(1);
        end
        else if (cmd.write && free_any)
        begin
            // New entry is youngest and most recent
            for (int j = 0; j < MAX_ENTRIES; j++)
            begin
                if (free_oh[j])
                begin
                    valid_next[j] = 1'b1;
                    rec_next[j]   = occ_rank;
                    ins_next[j]   = occ_rank;
                end
            end
            occ_next = occ_reg + CNT_W'(1);
        end
    end

    // Control state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= tlbfl_pkg::LIMIT_RESET;
            mode_reg      <= tlbfl_pkg::MODE_FIFO;
            valid_reg     <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tlbfl_pkg::REG_ENTRIES_IN_USE: limit_reg <= cfg_data;
                    tlbfl_pkg::REG_REPLACE_MODE:   mode_reg  <= cfg_data[0];
                    default:                       limit_reg <= limit_reg;
                endcase
            end
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Ranks and payload, no reset
    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        ins_reg <= ins_next;
        if (cmd.accept)
        begin
            page_reg   <= page_number;
            frame_reg  <= frame_number;
            scan_k_reg <= '0;
            hit_reg    <= 1'b0;
            found_reg  <= '0;
        end
        if (cmd.scan_issue)
        begin
            scan_k_reg  <= scan_k_reg + CNT_W'(1);
            scan_oh_reg <= scan_oh;
            scan_ok_reg <= scan_any;
        end
        if (cmp_match)
        begin
            hit_reg   <= 1'b1;
            found_reg <= rd_frame;
        end
        if (cmd.load_out)
        begin
            out_hit_reg   <= hit_reg;
            out_frame_reg <= found_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = out_hit_reg;
    assign found_frame = out_frame_reg;

endmodule

[hdl/tlb_fifo_lru.sv]
// Lookup: accept, scan, then result (one entry read per cycle
//   through the page/frame RAM port, in insertion order); next accept in the cycle after the result load.
// Insert: evict (only when at the limit), write, then result; flush, empty or disabled ops go straight to result.
// One transaction at a time; input is stalled until its result is registered.
// Reset: valid bits and occupancy clear at once, limit 16, FIFO policy; no sweep.
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlb_fifo_lru
// Fully associative TLB with FIFO or LRU replacement, built as a controller
// and a datapath around a page/frame RAM.
// ---------------------------------------------------------------------------
module tlb_fifo_lru #(
    parameter int MAX_ENTRIES = tlbfl_pkg::DEF_MAX_ENTRIES,
    parameter int PAGE_BITS   = tlbfl_pkg::DEF_PAGE_BITS,
    parameter int FRAME_BITS  = tlbfl_pkg::DEF_FRAME_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [tlbfl_pkg::CMD_BITS-1:0]       command,
    input  logic [PAGE_BITS-1:0]                 page_number,
    input  logic [FRAME_BITS-1:0]                frame_number,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 hit,
    output logic [FRAME_BITS-1:0]                found_frame,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tlbfl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tlbfl_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    tlbfl_pkg::ctrl_cmd_t  cmd;
    tlbfl_pkg::dp_status_t status;

    // Sequencer
    tlbfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Entry storage and result path
    tlbfl_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .PAGE_BITS   (PAGE_BITS),
        .FRAME_BITS  (FRAME_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .page_number  (page_number),
        .frame_number (frame_number),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .found_frame  (found_frame)
    );

endmodule

[hdl/tlbfl_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlbfl_checker
// Port-level checks on the TLB: one transaction in flight, miss results
// carry a zero frame, configuration stays open, stalled results hold.
// ---------------------------------------------------------------------------
`include "tlb_fifo_lru_defines.svh"

module tlbfl_checker #(
    parameter int FRAME_BITS = tlbfl_pkg::DEF_FRAME_BITS
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic                  hit,
    input logic [FRAME_BITS-1:0] found_frame,
    input logic                  cfg_ready
);

    // An accepted transaction blocks the input until its result is registered
    `TLBFL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    // A miss or a non-lookup result reports frame zero
    `TLBFL_ASSERT_SAME(a_miss_zero_frame, out_valid && !hit, found_frame == '0)
    // Configuration port stays open once out of reset
    `TLBFL_ASSERT_NEXT(a_cfg_open, cfg_ready, cfg_ready)
    // A stalled result holds
    `TLBFL_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(hit) && $stable(found_frame))

endmodule

bind tlb_fifo_lru tlbfl_checker #(.FRAME_BITS(FRAME_BITS)) u_checker (.*);
